// ===== hw/rtl/afe_pkg.sv =====
package afe_pkg;

  localparam int MAX_ELEMENTS  = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int GROUP_SIZE    = 8;
  localparam int NUM_GROUPS    = MAX_ELEMENTS / GROUP_SIZE;
  localparam int IDX_W         = $clog2(MAX_ELEMENTS);
  localparam int SUB_W         = $clog2(GROUP_SIZE);
  localparam int GRP_W         = $clog2(NUM_GROUPS);

  localparam int OP_W     = 4;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int FOUND_W  = 6;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 4'd0,
    OP_SET    = 4'd1,
    OP_PUSH   = 4'd2,
    OP_POP    = 4'd3,
    OP_INSERT = 4'd4,
    OP_REMOVE = 4'd5,
    OP_FIND   = 4'd6,
    OP_FILL   = 4'd7,
    OP_CLEAR  = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BOUNDS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_FILL   = 3'd4
  } act_t;

  typedef struct packed {
    act_t                     act;
    logic [POS_W-1:0]         pos;
    logic [POS_W-1:0]         rd_pos;
    logic [CNT_W-1:0]         count;
    logic [ELEMENT_WIDTH-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic                     read_hit;
    logic [ELEMENT_WIDTH-1:0] read_data;
    logic                     find_hit;
    logic [SUB_W-1:0]         find_sub;
  } group_res_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] element_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   element_out;
    logic [FOUND_W-1:0]  found_position;
    logic [CNT_W-1:0]    count;
  } out_item_t;

endpackage

// ===== hw/rtl/afe_cell.sv =====
module afe_cell (
  input  logic                              clk,
  input  logic [afe_pkg::IDX_W-1:0]         index,
  input  afe_pkg::cell_cmd_t                cmd,
  input  logic [afe_pkg::ELEMENT_WIDTH-1:0] left,
  input  logic [afe_pkg::ELEMENT_WIDTH-1:0] right,
  output logic [afe_pkg::ELEMENT_WIDTH-1:0] value,
  output logic                              read_hit,
  output logic                              find_hit
);
  import afe_pkg::*;

  logic [POS_W-1:0]         idx;
  logic [ELEMENT_WIDTH-1:0] value_next;

  assign idx = POS_W'(index);

  always_comb begin
    value_next = value;
    case (cmd.act)
      ACT_WRITE: begin
        if (idx == cmd.pos) value_next = cmd.value;
      end
      ACT_INSERT: begin
        // Slots past the insert point up to the old count take their left neighbor.
        if (idx == cmd.pos) value_next = cmd.value;
        else if (idx > cmd.pos && idx <= cmd.count) value_next = left;
      end
      ACT_REMOVE: begin
        if (idx >= cmd.pos && (idx + POS_W'(1)) < cmd.count) value_next = right;
      end
      ACT_FILL: value_next = cmd.value;
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign read_hit = (idx == cmd.rd_pos);
  assign find_hit = (idx < cmd.count) && (value == cmd.value);

endmodule

// ===== hw/rtl/afe_group.sv =====
module afe_group (
  input  logic                                                     clk,
  input  logic                                                     load,
  input  logic [afe_pkg::GROUP_SIZE-1:0]                           read_hit,
  input  logic [afe_pkg::GROUP_SIZE-1:0]                           find_hit,
  input  logic [afe_pkg::GROUP_SIZE-1:0][afe_pkg::ELEMENT_WIDTH-1:0] data,
  output afe_pkg::group_res_t                                      res
);
  import afe_pkg::*;

  group_res_t res_next;

  always_comb begin
    res_next           = '0;
    res_next.read_hit  = |read_hit;
    res_next.find_hit  = |find_hit;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (read_hit[i]) res_next.read_data = res_next.read_data | data[i];
    end
    // Scan downward so the lowest matching slot wins.
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (find_hit[i]) res_next.find_sub = SUB_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

endmodule

// ===== hw/rtl/fixed_capacity_array_engine.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item  (op, position, element_in)
// out       output     out_valid / out_ready  out_item (status, element_out,
//                                                       found_position, count)
// cfg       input      cfg_we                 cfg_data (capacity)
//
// Each item runs through S_EXEC and S_RED. In S_EXEC the row of cells shifts,
// writes and compares every slot at once while the group registers pick the read
// value and the first match; in S_RED the groups feed the output register.
// in_ready is high again in the cycle after the result enters the output register.
// rst is synchronous; it empties the array and sets the capacity to its maximum.
// A stalled output holds its beat; the engine still takes one more beat and then
// waits in its last stage until the output register is free.
module fixed_capacity_array_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  afe_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output afe_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [afe_pkg::CNT_W-1:0]  cfg_data
);
  import afe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RED  = 3'b100
  } state_t;

  state_t            state;
  in_item_t          item;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  capacity;
  status_t           status_exec;
  status_t           res_status;
  logic [CNT_W-1:0]  res_count;
  logic              res_read;
  logic              res_find;
  logic              read_ok;
  cell_cmd_t         cmd;
  op_t               op;

  logic [MAX_ELEMENTS-1:0][ELEMENT_WIDTH-1:0] cell_value;
  logic [MAX_ELEMENTS-1:0]                    cell_read_hit;
  logic [MAX_ELEMENTS-1:0]                    cell_find_hit;
  group_res_t                                 grp [NUM_GROUPS];

  out_item_t         result;
  logic              finish;

  assign in_ready = (state == S_IDLE);
  assign op       = op_t'(item.op);

  always_comb begin
    cmd         = '0;
    cmd.act     = ACT_HOLD;
    cmd.pos     = item.position;
    cmd.rd_pos  = item.position;
    cmd.count   = count;
    cmd.value   = item.element_in;
    status_exec = ST_OK;
    count_next  = count;
    read_ok     = 1'b0;
    case (op)
      OP_GET: begin
        if (item.position >= count) status_exec = ST_BOUNDS;
        else read_ok = 1'b1;
      end
      OP_SET: begin
        if (item.position >= count) status_exec = ST_BOUNDS;
        else cmd.act = ACT_WRITE;
      end
      OP_PUSH: begin
        cmd.pos = count;
        if (count >= capacity) status_exec = ST_FULL;
        else begin
          cmd.act    = ACT_WRITE;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        cmd.rd_pos = count - CNT_W'(1);
        if (count == '0) status_exec = ST_EMPTY;
        else begin
          read_ok    = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        // A position past the end reports bounds even when the array is full.
        if (item.position > count) status_exec = ST_BOUNDS;
        else if (count >= capacity) status_exec = ST_FULL;
        else begin
          cmd.act    = ACT_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (item.position >= count) status_exec = ST_BOUNDS;
        else begin
          cmd.act    = ACT_REMOVE;
          count_next = count - CNT_W'(1);
        end
      end
      OP_FIND: status_exec = ST_NOTFOUND;
      OP_FILL: begin
        cmd.act    = ACT_FILL;
        count_next = capacity;
      end
      OP_CLEAR: count_next = '0;
      default: status_exec = ST_OK;
    endcase
    if (state != S_EXEC) cmd.act = ACT_HOLD;
  end

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_in;
    logic [ELEMENT_WIDTH-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_value[g-1];
    end
    if (g == MAX_ELEMENTS - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_value[g+1];
    end
    afe_cell u_cell (
      .clk      (clk),
      .index    (IDX_W'(g)),
      .cmd      (cmd),
      .left     (left_in),
      .right    (right_in),
      .value    (cell_value[g]),
      .read_hit (cell_read_hit[g]),
      .find_hit (cell_find_hit[g])
    );
  end

  for (genvar k = 0; k < NUM_GROUPS; k++) begin : g_group
    afe_group u_group (
      .clk      (clk),
      .load     (state == S_EXEC),
      .read_hit (cell_read_hit[k*GROUP_SIZE +: GROUP_SIZE]),
      .find_hit (cell_find_hit[k*GROUP_SIZE +: GROUP_SIZE]),
      .data     (cell_value[k*GROUP_SIZE +: GROUP_SIZE]),
      .res      (grp[k])
    );
  end

  always_comb begin
    logic [ELEMENT_WIDTH-1:0] rd;
    logic                     any_find;
    logic [GRP_W-1:0]         first_grp;
    logic [SUB_W-1:0]         first_sub;
    rd        = '0;
    any_find  = 1'b0;
    first_grp = '0;
    first_sub = '0;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      if (grp[k].read_hit) rd = rd | grp[k].read_data;
    end
    for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
      if (grp[k].find_hit) begin
        any_find  = 1'b1;
        first_grp = GRP_W'(k);
        first_sub = grp[k].find_sub;
      end
    end
    result                = '0;
    result.status         = res_status;
    result.count          = res_count;
    if (res_read) result.element_out = DATA_W'(rd);
    if (res_find && any_find) begin
      result.status         = ST_OK;
      result.found_position = FOUND_W'({first_grp, first_sub});
    end
  end

  assign finish = (state == S_RED) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CNT_W'(MAX_ELEMENTS);
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          count <= count_next;
          state <= S_RED;
        end
        S_RED: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      // A capacity of zero or above the store size is ignored.
      if (cfg_we && cfg_data != '0 && cfg_data <= CNT_W'(MAX_ELEMENTS)) begin
        capacity <= cfg_data;
        count    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_item;
    if (state == S_EXEC) begin
      res_status <= status_exec;
      res_count  <= count_next;
      res_read   <= read_ok;
      res_find   <= (op == OP_FIND);
    end
    if (finish) out_item <= result;
  end

endmodule

// ===== bench/array_engine_checker.sv =====
module array_engine_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  afe_pkg::in_item_t         in_item,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  afe_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [afe_pkg::CNT_W-1:0] cfg_data,
  output int                        outstanding,
  output int                        mismatches
);
  import afe_pkg::*;

  logic [DATA_W-1:0] slots [MAX_ELEMENTS];
  int                used;
  int                cap;
  out_item_t         outcomes_due [$];
  out_item_t         due;

  function automatic out_item_t apply_array_op(input in_item_t it);
    out_item_t         r;
    int                pos;
    logic [DATA_W-1:0] val;
    r   = '0;
    pos = int'(it.position);
    val = it.element_in;
    r.status = ST_OK;
    if (used > cap) used = cap;
    case (it.op)
      OP_GET: begin
        if (pos >= used) r.status = ST_BOUNDS;
        else r.element_out = slots[pos];
      end
      OP_SET: begin
        if (pos >= used) r.status = ST_BOUNDS;
        else slots[pos] = val;
      end
      OP_PUSH: begin
        if (used >= cap) r.status = ST_FULL;
        else begin
          slots[used] = val;
          used++;
        end
      end
      OP_POP: begin
        if (used == 0) r.status = ST_EMPTY;
        else begin
          used--;
          r.element_out = slots[used];
        end
      end
      OP_INSERT: begin
        // An insert past the end reports bounds even when the array is full.
        if (pos > used) r.status = ST_BOUNDS;
        else if (used >= cap) r.status = ST_FULL;
        else begin
          for (int i = used; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = val;
          used++;
        end
      end
      OP_REMOVE: begin
        if (pos >= used) r.status = ST_BOUNDS;
        else begin
          for (int i = pos; i + 1 < used; i++) slots[i] = slots[i+1];
          used--;
        end
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < used; i++) begin
          if (r.status == ST_NOTFOUND && slots[i] == val) begin
            r.status         = ST_OK;
            r.found_position = FOUND_W'(i);
          end
        end
      end
      OP_FILL: begin
        for (int i = 0; i < cap; i++) slots[i] = val;
        used = cap;
      end
      OP_CLEAR: used = 0;
      default: ;
    endcase
    r.count = CNT_W'(used);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      used = 0;
      cap  = MAX_ELEMENTS;
      outcomes_due.delete();
      mismatches = 0;
    end else begin
      // Out-of-range capacity writes are dropped by the block.
      if (cfg_we && cfg_data != 0 && cfg_data <= MAX_ELEMENTS) begin
        cap  = int'(cfg_data);
        used = 0;
      end
      if (out_valid && out_ready) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: st=%0d out=%h pos=%0d cnt=%0d",
                     out_item.status, out_item.element_out,
                     out_item.found_position, out_item.count);
        end else begin
          due = outcomes_due.pop_front();
          if (due !== out_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %0d %h %0d %0d, got %0d %h %0d %0d",
                       due.status, due.element_out, due.found_position, due.count,
                       out_item.status, out_item.element_out,
                       out_item.found_position, out_item.count);
          end
        end
      end
      if (in_valid && in_ready)
        outcomes_due.insert(outcomes_due.size(), apply_array_op(in_item));
    end
    outstanding = outcomes_due.size();
  end

endmodule

// ===== bench/tb_fixed_capacity_array_engine.sv =====
module tb_fixed_capacity_array_engine;
  import afe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_data;
  int                 outstanding;
  int                 mismatches;
  int                 cycles;
  bit                 calm;
  int                 cap_now;
  logic [DATA_W-1:0]  value_pool [8];

  fixed_capacity_array_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  array_engine_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                      input logic [DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {op, pos, val};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input int v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= CNT_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (v >= 1 && v <= MAX_ELEMENTS) cap_now = v;
  endtask

  task automatic random_item();
    int                pick;
    logic [OP_W-1:0]   op;
    int                pos;
    logic [DATA_W-1:0] val;
    pick = $urandom_range(99);
    if (pick < 20)      op = OP_PUSH;
    else if (pick < 32) op = OP_GET;
    else if (pick < 42) op = OP_SET;
    else if (pick < 52) op = OP_INSERT;
    else if (pick < 62) op = OP_REMOVE;
    else if (pick < 74) op = OP_FIND;
    else if (pick < 86) op = OP_POP;
    else if (pick < 90) op = OP_FILL;
    else if (pick < 94) op = OP_CLEAR;
    else                op = OP_W'($urandom_range(15, 9));
    // Mostly positions near the live range, now and then anything the field holds.
    if ($urandom_range(9) == 0) pos = $urandom_range(127);
    else pos = $urandom_range(cap_now);
    if ($urandom_range(1)) val = value_pool[$urandom_range(7)];
    else val = $urandom;
    send(op, POS_W'(pos), val);
  endtask

  initial begin
    int caps [PHASES];
    in_valid = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    calm     = 1'b0;
    cap_now  = MAX_ELEMENTS;
    rst      = 1'b1;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty array, bounds, opcode and capacity corner cases.
    send(OP_POP, 0, 0);
    send(OP_GET, 0, 0);
    send(OP_FIND, 0, 0);
    send(OP_REMOVE, 0, 0);
    send(OP_INSERT, 1, 32'hDEADBEEF);
    send(OP_PUSH, 0, 32'hFFFFFFFF);
    send(OP_PUSH, 0, 32'h00000000);
    send(OP_INSERT, 0, 32'hA5A5A5A5);
    send(OP_INSERT, 3, 32'h3C3C3C3C);
    send(OP_GET, 0, 0);
    send(OP_GET, 3, 0);
    send(OP_SET, 1, 32'h5A5A5A5A);
    send(OP_FIND, 0, 32'h00000000);
    send(OP_REMOVE, 0, 0);
    send(OP_GET, 127, 0);
    send(4'd9, 127, 32'hFFFFFFFF);
    send(4'd15, 0, 0);
    send(OP_FILL, 0, 32'h12345678);
    set_capacity(0);
    set_capacity(127);
    set_capacity(65);
    send(OP_PUSH, 0, 32'h1);
    send(OP_INSERT, 64, 32'h2);
    send(OP_INSERT, 100, 32'h3);
    send(OP_FIND, 0, 32'h12345678);
    send(OP_REMOVE, 63, 0);
    send(OP_POP, 0, 0);
    send(OP_CLEAR, 0, 0);

    caps[0] = 1;
    caps[1] = 2;
    caps[2] = MAX_ELEMENTS;
    caps[3] = $urandom_range(63, 3);
    caps[4] = 63;
    caps[5] = $urandom_range(8, 1);
    caps[6] = MAX_ELEMENTS;
    caps[7] = $urandom_range(MAX_ELEMENTS, 1);
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(caps[p]);
      calm = (p == 2);
      for (int n = 0; n < 205; n++) random_item();
    end
    calm = 1'b0;

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
